[rtl/bmft_pkg.sv]
// Shared constants, types and helpers for the block-mapped flash translation block.
// Used by the interfaces, controller, datapath and top level. No dependencies.
`timescale 1ns / 1ps

package bmft_pkg;

    // Geometry
    localparam int DATA_BLOCKS   = 16;
    localparam int PAGES_PER_BLK = 4;
    localparam int SECTOR_BITS   = 32;
    localparam int PHYS_BLOCKS   = DATA_BLOCKS + 1;
    localparam int PHYS_PAGES    = PHYS_BLOCKS * PAGES_PER_BLK;
    localparam int LOG_SECTORS   = DATA_BLOCKS * PAGES_PER_BLK;

    // Field and index widths
    localparam int LSN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = $clog2(PAGES_PER_BLK);
    localparam int LBN_W    = $clog2(DATA_BLOCKS);
    localparam int PBN_W    = $clog2(PHYS_BLOCKS);
    localparam int PAGE_W   = $clog2(PHYS_PAGES);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             exec;
        logic             cap_rd;
        logic             copy_rd;
        logic             copy_wr;
        logic             merge_end;
        logic             scan;
        logic             finish;
        logic [OFF_W-1:0] idx;
        logic [PBN_W-1:0] scan_idx;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic             range_err;
        logic             is_write;
        logic             mapped;
        logic             cur_written;
        logic             scan_free;
        logic             out_free;
        logic [OFF_W-1:0] off;
    } t_sts;

    // Physical page number of a page offset inside a physical block
    function automatic logic [PAGE_W-1:0] page_of(logic [PBN_W-1:0] pbn,
                                                  logic [OFF_W-1:0] off);
        page_of = PAGE_W'(pbn) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(off);
    endfunction

endpackage

[rtl/bmft_req_if.sv]
// Request channel: valid/ready handshake with operation, sector number and data.
// Depends on bmft_pkg.
`timescale 1ns / 1ps

interface bmft_req_if;
    import bmft_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [LSN_W-1:0]       lsn;
    logic [SECTOR_BITS-1:0] write_data;

    modport source (output valid, output operation, output lsn, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input lsn, input write_data,
                    output ready);
endinterface

[rtl/bmft_rsp_if.sv]
// Response channel: valid/ready handshake with read data, status and mapping info.
// Depends on bmft_pkg.
`timescale 1ns / 1ps

interface bmft_rsp_if;
    import bmft_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SECTOR_BITS-1:0] read_data;
    logic [STATUS_W-1:0]    status;
    logic [PAGE_W-1:0]      physical_page;
    logic                   merged;
    logic [PBN_W-1:0]       spare_after;

    modport source (output valid, output read_data, output status,
                    output physical_page, output merged, output spare_after,
                    input ready);
    modport sink   (input valid, input read_data, input status,
                    input physical_page, input merged, input spare_after,
                    output ready);
endinterface

[rtl/bmft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bmft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bmft_ctrl.sv]
// Sequencer for the translation block: decides each request's flow and steps
// merge copies and spare search. Depends on bmft_pkg.
`timescale 1ns / 1ps

module bmft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bmft_pkg::t_sts  i_sts,
    output bmft_pkg::t_cmd  o_cmd
);
    import bmft_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_RDWAIT  = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_COPY_RD = 3'd4;
    localparam logic [2:0] S_COPY_WR = 3'd5;
    localparam logic [2:0] S_MERGE   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [OFF_W-1:0] r_idx, n_idx;
    logic [PBN_W-1:0] r_scan, n_scan;
    logic             idx_last;

    assign idx_last   = (r_idx == OFF_W'(PAGES_PER_BLK - 1));
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_scan  = r_scan;
        o_cmd   = '0;
        o_cmd.idx      = r_idx;
        o_cmd.scan_idx = r_scan;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_sts.range_err) begin
                    n_state = S_DONE;
                end else if (!i_sts.is_write) begin
                    n_state = i_sts.mapped ? S_RDWAIT : S_DONE;
                end else if (!i_sts.mapped) begin
                    n_scan  = PBN_W'(PHYS_BLOCKS - 1);
                    n_state = S_SCAN;
                end else if (i_sts.cur_written) begin
                    n_idx   = '0;
                    n_state = S_COPY_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                // walk down from the highest block until an unused one turns up or block 0 is reached
                o_cmd.scan = 1'b1;
                if (i_sts.scan_free || r_scan == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_scan = r_scan - 1'b1;
                end
            end
            S_COPY_RD: begin
                // skip the page being rewritten
                if (r_idx == i_sts.off) begin
                    if (idx_last) begin
                        n_state = S_MERGE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    o_cmd.copy_rd = 1'b1;
                    n_state       = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                if (idx_last) begin
                    n_state = S_MERGE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_COPY_RD;
                end
            end
            S_MERGE: begin
                o_cmd.merge_end = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_scan  <= n_scan;
        end
    end

    // A copy write always follows the read of the same page
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.copy_wr |-> $past(o_cmd.copy_rd))
        else $error("copy write without preceding copy read");

    // An accepted request is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted request not executed");

    // Spare search stays within the physical blocks
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan |-> (r_scan <= PBN_W'(PHYS_BLOCKS - 1)))
        else $error("spare search index out of range");
endmodule

[rtl/bmft_dp.sv]
// Datapath: block map, in-use and written bits, spare register, page RAM and
// response register. Depends on bmft_pkg and bmft_ram.
`timescale 1ns / 1ps

module bmft_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bmft_pkg::t_cmd                   i_cmd,
    output bmft_pkg::t_sts                   o_sts,
    input  logic                             i_operation,
    input  logic [bmft_pkg::LSN_W-1:0]       i_lsn,
    input  logic [bmft_pkg::SECTOR_BITS-1:0] i_write_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [bmft_pkg::SECTOR_BITS-1:0] o_read_data,
    output logic [bmft_pkg::STATUS_W-1:0]    o_status,
    output logic [bmft_pkg::PAGE_W-1:0]      o_physical_page,
    output logic                             o_merged,
    output logic [bmft_pkg::PBN_W-1:0]       o_spare_after
);
    import bmft_pkg::*;

    // Request registers
    logic                   r_op;
    logic [LSN_W-1:0]       r_lsn;
    logic [SECTOR_BITS-1:0] r_wdata;

    // Translation state
    logic [PBN_W-1:0]       r_map [DATA_BLOCKS];
    logic [DATA_BLOCKS-1:0] r_map_vld;
    logic [PHYS_BLOCKS-1:0] r_in_use;
    logic [PHYS_PAGES-1:0]  r_written;
    logic [PBN_W-1:0]       r_spare;
    logic [PBN_W-1:0]       r_src;
    logic [PBN_W-1:0]       r_dst;

    // Result under construction and response register
    logic [SECTOR_BITS-1:0] r_rdata;
    logic [STATUS_W-1:0]    r_status;
    logic [PAGE_W-1:0]      r_ppage;
    logic                   r_merged;
    logic                   r_out_valid;
    logic [SECTOR_BITS-1:0] r_out_rdata;
    logic [STATUS_W-1:0]    r_out_status;
    logic [PAGE_W-1:0]      r_out_ppage;
    logic                   r_out_merged;
    logic [PBN_W-1:0]       r_out_spare;

    // Decode
    logic                   range_err;
    logic [LBN_W-1:0]       lbn;
    logic [OFF_W-1:0]       off;
    logic [PBN_W-1:0]       map_pbn;
    logic                   mapped;
    logic [PAGE_W-1:0]      cur_page;
    logic [PAGE_W-1:0]      new_page;
    logic [PAGE_W-1:0]      src_page;
    logic [PAGE_W-1:0]      dst_page;
    logic [PAGE_W-1:0]      merge_page;
    logic                   cur_written;
    logic                   do_claim;
    logic                   do_program;
    logic                   do_merge_start;
    logic [STATUS_W-1:0]    exec_status;
    logic [PAGE_W-1:0]      exec_ppage;

    // RAM port signals
    logic                   ram_we;
    logic [PAGE_W-1:0]      ram_waddr;
    logic [SECTOR_BITS-1:0] ram_wdata;
    logic [PAGE_W-1:0]      ram_raddr;
    logic [SECTOR_BITS-1:0] ram_rdata;

    // Split the sector number and look up the mapping
    assign range_err   = (r_lsn >= LSN_W'(LOG_SECTORS));
    assign lbn         = r_lsn[OFF_W +: LBN_W];
    assign off         = r_lsn[OFF_W-1:0];
    assign map_pbn     = r_map[lbn];
    assign mapped      = r_map_vld[lbn];
    assign cur_page    = page_of(map_pbn, off);
    assign new_page    = page_of(r_spare, off);
    assign src_page    = page_of(r_src, i_cmd.idx);
    assign dst_page    = page_of(r_dst, i_cmd.idx);
    assign merge_page  = page_of(r_dst, off);
    assign cur_written = r_written[cur_page];

    assign do_claim       = i_cmd.exec && !range_err && r_op && !mapped;
    assign do_program     = i_cmd.exec && !range_err && r_op && mapped && !cur_written;
    assign do_merge_start = i_cmd.exec && !range_err && r_op && mapped && cur_written;

    // Status toward the controller
    always_comb begin
        o_sts             = '0;
        o_sts.range_err   = range_err;
        o_sts.is_write    = r_op;
        o_sts.mapped      = mapped;
        o_sts.cur_written = cur_written;
        o_sts.scan_free   = !r_in_use[i_cmd.scan_idx];
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.off         = off;
    end

    // Result status and page for this request
    always_comb begin
        priority if (range_err) begin
            exec_status = ST_RANGE;
            exec_ppage  = '0;
        end else if (!r_op && !mapped) begin
            exec_status = ST_UNMAPPED;
            exec_ppage  = '0;
        end else if (r_op && (!mapped || cur_written)) begin
            exec_status = ST_OK;
            exec_ppage  = new_page;
        end else begin
            exec_status = ST_OK;
            exec_ppage  = cur_page;
        end
    end

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = new_page;
        ram_wdata = r_wdata;
        ram_raddr = i_cmd.copy_rd ? src_page : cur_page;
        priority if (do_claim) begin
            ram_we    = 1'b1;
            ram_waddr = new_page;
        end else if (do_program) begin
            ram_we    = 1'b1;
            ram_waddr = cur_page;
        end else if (i_cmd.copy_wr) begin
            ram_we    = 1'b1;
            ram_waddr = dst_page;
            ram_wdata = ram_rdata;
        end else if (i_cmd.merge_end) begin
            ram_we    = 1'b1;
            ram_waddr = merge_page;
        end else begin
            ram_we    = 1'b0;
        end
    end

    bmft_ram #(
        .WIDTH (SECTOR_BITS),
        .DEPTH (PHYS_PAGES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state: mapping valid, block usage, page written bits, spare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld   <= '0;
            r_in_use    <= '0;
            r_written   <= '0;
            r_spare     <= PBN_W'(DATA_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            // claim the spare for an unmapped block
            if (do_claim) begin
                r_map_vld[lbn]      <= 1'b1;
                r_in_use[r_spare]   <= 1'b1;
                r_written[new_page] <= 1'b1;
            end
            if (do_program) begin
                r_written[cur_page] <= 1'b1;
            end
            // carry the written flag along with the copied page
            if (i_cmd.copy_wr) begin
                r_written[dst_page] <= r_written[src_page];
            end
            // erase the old block, which becomes the spare
            if (i_cmd.merge_end) begin
                for (int i = 0; i < PAGES_PER_BLK; i++) begin
                    r_written[page_of(r_src, OFF_W'(i))] <= 1'b0;
                end
                r_written[merge_page] <= 1'b1;
                r_in_use[r_dst]       <= 1'b1;
                r_in_use[r_src]       <= 1'b0;
                r_spare               <= r_src;
            end
            if (i_cmd.scan && !r_in_use[i_cmd.scan_idx]) begin
                r_spare <= i_cmd.scan_idx;
            end
            // response handshake
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request capture, mapping entries, result build-up
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_lsn   <= i_lsn;
            r_wdata <= i_write_data;
        end
        if (i_cmd.exec) begin
            r_rdata  <= '1;
            r_merged <= 1'b0;
            r_status <= exec_status;
            r_ppage  <= exec_ppage;
        end
        if (do_claim) begin
            r_map[lbn] <= r_spare;
        end
        if (do_merge_start) begin
            r_src <= map_pbn;
            r_dst <= r_spare;
        end
        // unwritten pages read as erased
        if (i_cmd.cap_rd && r_written[r_ppage]) begin
            r_rdata <= ram_rdata;
        end
        if (i_cmd.merge_end) begin
            r_map[lbn] <= r_dst;
            r_merged   <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_rdata  <= r_rdata;
            r_out_status <= r_status;
            r_out_ppage  <= r_ppage;
            r_out_merged <= r_merged;
            r_out_spare  <= r_spare;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_rdata;
    assign o_status        = r_out_status;
    assign o_physical_page = r_out_ppage;
    assign o_merged        = r_out_merged;
    assign o_spare_after   = r_out_spare;

    // The spare is a real physical block
    a_spare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare <= PBN_W'(PHYS_BLOCKS - 1))
        else $error("spare block out of range");

    // When a response is issued the spare is not in use
    a_spare_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_in_use[r_spare])
        else $error("spare block marked in use");

    // At most one block per logical block is in use
    a_in_use_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_use) <= DATA_BLOCKS)
        else $error("too many blocks in use");

    // A merge never copies a block onto itself
    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_end |-> (r_src != r_dst))
        else $error("merge source equals destination");
endmodule

[rtl/block_mapped_flash_translation.sv]
// Block-mapped flash translation: one response per request, one request in flight.
// Range errors, unmapped reads and plain writes go straight to the response register;
// reads first capture the registered RAM data; a block claim searches down for a new
// spare, and a merge copies each other page through the single page RAM port pair.
// Reset clears mapping valid, block usage and page written bits at once; the page RAM
// is not cleared, unwritten pages read as all ones.
`timescale 1ns / 1ps

module block_mapped_flash_translation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmft_req_if.sink    i_req,
    bmft_rsp_if.source  o_rsp
);
    import bmft_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_req.ready = in_ready;

    // Sequencer
    bmft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Translation state and page store
    bmft_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_req.operation),
        .i_lsn           (i_req.lsn),
        .i_write_data    (i_req.write_data),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_read_data     (o_rsp.read_data),
        .o_status        (o_rsp.status),
        .o_physical_page (o_rsp.physical_page),
        .o_merged        (o_rsp.merged),
        .o_spare_after   (o_rsp.spare_after)
    );
endmodule

[tb/sv/block_mapped_flash_translation_tb.sv]
// Self-checking testbench for block_mapped_flash_translation: random sector reads and
// writes with handshake gaps, checked against a built-in block-mapping predictor.
// Depends on bmft_pkg, bmft_req_if, bmft_rsp_if and the block itself.
`timescale 1ns / 1ps

module block_mapped_flash_translation_tb;
    import bmft_pkg::*;

    localparam bit OP_READ  = 1'b0;
    localparam bit OP_WRITE = 1'b1;
    localparam logic [SECTOR_BITS-1:0] ERASED = '1;

    typedef struct {
        bit                     op;
        logic [LSN_W-1:0]       lsn;
        logic [SECTOR_BITS-1:0] data;
        int                     gap;
    } t_sector_req;

    typedef struct {
        logic [SECTOR_BITS-1:0] read_data;
        logic [STATUS_W-1:0]    status;
        logic [PAGE_W-1:0]      physical_page;
        logic                   merged;
        logic [PBN_W-1:0]       spare_after;
    } t_sector_rsp;

    logic i_clk;
    logic i_rst_n;

    bmft_req_if req_ch ();
    bmft_rsp_if rsp_ch ();

    block_mapped_flash_translation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Predictor state: logical-to-physical map, block usage and flash contents
    logic [PBN_W-1:0]       map_pbn   [DATA_BLOCKS];
    bit                     map_ok    [DATA_BLOCKS];
    bit                     blk_used  [PHYS_BLOCKS];
    bit                     pg_written[PHYS_PAGES];
    logic [SECTOR_BITS-1:0] pg_data   [PHYS_PAGES];
    logic [PBN_W-1:0]       spare_blk;

    t_sector_req pending_reqs[$];
    t_sector_rsp expected_rsps[$];

    logic req_fire;
    logic rsp_fire;
    logic rsp_hold;
    int   req_idle_cnt;
    int   rsp_stall;
    int   requests_accepted;
    int   responses_checked;
    int   error_count;
    int   n_reads, n_writes, n_merges, n_claims, n_range, n_unmapped;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Flash translation predictor; updates the shadow state for one request
    function automatic t_sector_rsp translate_sector(t_sector_req r);
        t_sector_rsp      res;
        int               lbn;
        int               off;
        int               pbn;
        int               dst;
        int               cur;
        res.read_data     = ERASED;
        res.status        = ST_OK;
        res.physical_page = '0;
        res.merged        = 1'b0;
        if (r.lsn >= LOG_SECTORS) begin
            res.status = ST_RANGE;
            n_range++;
        end else begin
            lbn = r.lsn / PAGES_PER_BLK;
            off = r.lsn % PAGES_PER_BLK;
            if (r.op == OP_READ) begin
                n_reads++;
                if (!map_ok[lbn]) begin
                    res.status = ST_UNMAPPED;
                    n_unmapped++;
                end else begin
                    cur = map_pbn[lbn] * PAGES_PER_BLK + off;
                    res.physical_page = PAGE_W'(cur);
                    if (pg_written[cur])
                        res.read_data = pg_data[cur];
                end
            end else if (!map_ok[lbn]) begin
                // Claim the spare, then pick the highest free block as the new spare
                n_writes++;
                n_claims++;
                pbn = spare_blk;
                map_pbn[lbn] = PBN_W'(pbn);
                map_ok[lbn]  = 1'b1;
                blk_used[pbn] = 1'b1;
                for (int b = PHYS_BLOCKS - 1; b >= 0; b--) begin
                    if (!blk_used[b]) begin
                        spare_blk = PBN_W'(b);
                        break;
                    end
                end
                cur = pbn * PAGES_PER_BLK + off;
                res.physical_page = PAGE_W'(cur);
                pg_data[cur]    = r.data;
                pg_written[cur] = 1'b1;
            end else begin
                n_writes++;
                pbn = map_pbn[lbn];
                cur = pbn * PAGES_PER_BLK + off;
                if (pg_written[cur]) begin
                    // Merge: copy the other pages to the spare, erase the old block
                    n_merges++;
                    dst = spare_blk;
                    for (int i = 0; i < PAGES_PER_BLK; i++) begin
                        if (i != off) begin
                            pg_data[dst * PAGES_PER_BLK + i]    = pg_data[pbn * PAGES_PER_BLK + i];
                            pg_written[dst * PAGES_PER_BLK + i] =
                                pg_written[pbn * PAGES_PER_BLK + i];
                        end
                    end
                    res.physical_page = PAGE_W'(dst * PAGES_PER_BLK + off);
                    pg_data[dst * PAGES_PER_BLK + off]    = r.data;
                    pg_written[dst * PAGES_PER_BLK + off] = 1'b1;
                    for (int i = 0; i < PAGES_PER_BLK; i++) begin
                        pg_data[pbn * PAGES_PER_BLK + i]    = ERASED;
                        pg_written[pbn * PAGES_PER_BLK + i] = 1'b0;
                    end
                    map_pbn[lbn]  = PBN_W'(dst);
                    blk_used[dst] = 1'b1;
                    blk_used[pbn] = 1'b0;
                    spare_blk     = PBN_W'(pbn);
                    res.merged    = 1'b1;
                end else begin
                    res.physical_page = PAGE_W'(cur);
                    pg_data[cur]    = r.data;
                    pg_written[cur] = 1'b1;
                end
            end
        end
        res.spare_after = spare_blk;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Sample both handshakes; predict on request, check on response
    always @(posedge i_clk) begin
        t_sector_req r;
        t_sector_rsp want;
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        rsp_fire <= i_rst_n && rsp_ch.valid && rsp_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            r.op   = req_ch.operation;
            r.lsn  = req_ch.lsn;
            r.data = req_ch.write_data;
            r.gap  = 0;
            expected_rsps.push_back(translate_sector(r));
            requests_accepted++;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: response with no request outstanding, actual status %h",
                         $time, rsp_ch.status);
                error_count++;
            end else begin
                want = expected_rsps.pop_front();
                check_field("read_data", want.read_data, rsp_ch.read_data);
                check_field("status", want.status, rsp_ch.status);
                check_field("physical_page", want.physical_page, rsp_ch.physical_page);
                check_field("merged", want.merged, rsp_ch.merged);
                check_field("spare_after", want.spare_after, rsp_ch.spare_after);
            end
            responses_checked++;
        end
    end

    // Request driver: idle each request's drawn gap before offering it, then hold it until taken
    always @(negedge i_clk) begin
        logic        offer;
        t_sector_req r;
        offer = req_ch.valid && !req_fire;
        if (i_rst_n && !offer && pending_reqs.size() > 0) begin
            if (req_idle_cnt < pending_reqs[0].gap) begin
                req_idle_cnt++;
            end else begin
                r = pending_reqs.pop_front();
                req_ch.operation  <= r.op;
                req_ch.lsn        <= r.lsn;
                req_ch.write_data <= r.data;
                offer        = 1'b1;
                req_idle_cnt = 0;
            end
        end
        req_ch.valid <= offer;
    end

    // Response sink: stall a drawn number of cycles per response, or hold off entirely
    always @(negedge i_clk) begin
        logic quiet;
        quiet = (requests_accepted / 150) % 4 == 1;
        if (rsp_fire)
            rsp_stall = quiet ? 0 : $urandom_range(0, 8);
        if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= i_rst_n;
        end
    end

    // Back-pressure: block the response side for a long stretch mid-run
    initial begin
        rsp_hold = 1'b0;
        while (requests_accepted < 400)
            @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // Stimulus, reset and end of run
    initial begin
        t_sector_req r;
        int          base;
        int          roll;
        bit          narrow;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_READ;
        req_ch.lsn        = '0;
        req_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        i_rst_n           = 1'b0;
        req_idle_cnt      = 0;
        rsp_stall         = 0;
        requests_accepted = 0;
        responses_checked = 0;
        error_count       = 0;
        n_reads = 0; n_writes = 0; n_merges = 0;
        n_claims = 0; n_range = 0; n_unmapped = 0;
        for (int i = 0; i < DATA_BLOCKS; i++) begin
            map_pbn[i] = '0;
            map_ok[i]  = 1'b0;
        end
        for (int i = 0; i < PHYS_BLOCKS; i++)
            blk_used[i] = 1'b0;
        for (int i = 0; i < PHYS_PAGES; i++) begin
            pg_written[i] = 1'b0;
            pg_data[i]    = ERASED;
        end
        spare_blk = PBN_W'(DATA_BLOCKS);

        // Directed: unmapped reads, range errors, claim, plain write, merge, erased pages
        r.gap = 0;
        r.op = OP_READ;  r.lsn = 0;   r.data = '0;           pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 64;  r.data = 32'h1234_5678; pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 127; r.data = '0;           pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 0;   r.data = 32'h0000_0000; pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 0;                          pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 3;                          pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 3;   r.data = 32'hFFFF_FFFF; pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 1;   r.data = 32'hA5A5_A5A5; pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 0;   r.data = 32'h1234_5678; pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 0;                          pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 1;                          pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 2;                          pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 3;                          pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 63;  r.data = 32'h5A5A_5A5A; pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 63;                         pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 63;  r.data = 32'hDEAD_BEEF; pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 62;                         pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 63;                         pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 4;                          pending_reqs.push_back(r);
        r.op = OP_WRITE; r.lsn = 127; r.data = 32'hFFFF_FFFF; pending_reqs.push_back(r);
        r.op = OP_READ;  r.lsn = 64;                         pending_reqs.push_back(r);
        foreach (pending_reqs[i])
            pending_reqs[i].gap = $urandom_range(0, 8);

        // Random: every third segment narrows the sectors to two adjacent blocks,
        // which drives frequent merges; some segments run without sender gaps
        for (int seg = 0; seg < 18; seg++) begin
            narrow = (seg % 3 == 1);
            base   = $urandom_range(0, DATA_BLOCKS - 2) * PAGES_PER_BLK;
            for (int k = 0; k < 100; k++) begin
                roll   = $urandom_range(0, 99);
                r.op   = 1'($urandom_range(0, 1));
                r.data = $urandom();
                if (roll < 7)
                    r.lsn = LSN_W'($urandom_range(LOG_SECTORS, 127));
                else if (narrow)
                    r.lsn = LSN_W'(base + $urandom_range(0, 2 * PAGES_PER_BLK - 1));
                else
                    r.lsn = LSN_W'($urandom_range(0, LOG_SECTORS - 1));
                r.gap = (seg % 4 == 1 || seg % 4 == 2) ? 0 : $urandom_range(0, 8);
                pending_reqs.push_back(r);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: everything sent and answered, then watch for stray responses
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d requests: %0d reads (%0d unmapped), %0d writes,",
                 requests_accepted, n_reads, n_unmapped, n_writes);
        $display("  %0d block claims, %0d merges, %0d out-of-range sectors, %0d errors",
                 n_claims, n_merges, n_range, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/bmft_pkg.sv
rtl/bmft_req_if.sv
rtl/bmft_rsp_if.sv
rtl/bmft_ram.sv
rtl/bmft_ctrl.sv
rtl/bmft_dp.sv
rtl/block_mapped_flash_translation.sv
tb/sv/block_mapped_flash_translation_tb.sv
